/* rtl/u2u_pkg.sv */
// Shared types and constants for the UTF-8 to UCS-2 decoder.
// No dependencies; used by every module of the decoder.
`default_nettype none

package u2u_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned UNIT_W  = 16;
  localparam int unsigned PEND_W  = 2;

  localparam logic [UNIT_W-1:0] UNIT_LIMIT_RST = 16'hFFFF;

  // Byte class masks and patterns
  localparam logic [BYTE_W-1:0] ASCII_MASK  = 8'h80;
  localparam logic [BYTE_W-1:0] LEAD2_MASK  = 8'hE0;
  localparam logic [BYTE_W-1:0] LEAD2_PAT   = 8'hC0;
  localparam logic [BYTE_W-1:0] LEAD3_MASK  = 8'hF0;
  localparam logic [BYTE_W-1:0] LEAD3_PAT   = 8'hE0;
  localparam logic [BYTE_W-1:0] CONT_BITS   = 8'h3F;
  localparam logic [BYTE_W-1:0] LEAD2_BITS  = 8'h1F;
  localparam logic [BYTE_W-1:0] LEAD3_BITS  = 8'h0F;

  // Following bytes still expected
  localparam logic [PEND_W-1:0] PEND_LEAD = 2'd0;
  localparam logic [PEND_W-1:0] PEND_ONE  = 2'd1;
  localparam logic [PEND_W-1:0] PEND_TWO  = 2'd2;

  // One decode result handed from the core to the output buffer
  typedef struct packed {
    logic              emit;
    logic [UNIT_W-1:0] code_unit;
    logic [UNIT_W-1:0] unit_count;
  } result_t;

endpackage

`default_nettype wire

/* rtl/u2u_core.sv */
// Decode state and per-byte next-state logic of the UTF-8 to UCS-2 decoder.
// Depends on u2u_pkg.
`default_nettype none

module u2u_core (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          accept,
  input  wire logic [u2u_pkg::BYTE_W-1:0]    in_byte,
  input  wire logic                          last_byte,
  input  wire logic [u2u_pkg::UNIT_W-1:0]    unit_limit,
  output u2u_pkg::result_t                   result
);

  logic [u2u_pkg::PEND_W-1:0] pend_r,    pend_nxt;
  logic [u2u_pkg::UNIT_W-1:0] partial_r, partial_nxt;
  logic [u2u_pkg::UNIT_W-1:0] units_r,   units_nxt;
  logic                       stop_r,    stop_nxt;

  logic [u2u_pkg::UNIT_W-1:0] cont6;
  logic                       emit;
  logic [u2u_pkg::UNIT_W-1:0] unit;
  logic [u2u_pkg::UNIT_W-1:0] units_inc;

  assign cont6 = {8'd0, in_byte & u2u_pkg::CONT_BITS};

  assign units_inc = units_r + u2u_pkg::UNIT_W'(1);

  always_comb begin
    pend_nxt    = pend_r;
    partial_nxt = partial_r;
    stop_nxt    = stop_r;
    emit        = 1'b0;
    unit        = '0;
    if (!stop_r) begin
      case (pend_r)
        u2u_pkg::PEND_LEAD: begin
          if (units_r >= unit_limit || in_byte == '0) begin
            stop_nxt = 1'b1;
          end else if ((in_byte & u2u_pkg::ASCII_MASK) == '0) begin
            unit = {8'd0, in_byte};
            emit = 1'b1;
          end else if ((in_byte & u2u_pkg::LEAD2_MASK) == u2u_pkg::LEAD2_PAT) begin
            partial_nxt = {5'd0, in_byte[4:0], 6'd0};
            pend_nxt    = u2u_pkg::PEND_ONE;
          end else if ((in_byte & u2u_pkg::LEAD3_MASK) == u2u_pkg::LEAD3_PAT) begin
            partial_nxt = {in_byte[3:0], 12'd0};
            pend_nxt    = u2u_pkg::PEND_TWO;
          end
          // anything else is a dropped lead byte
        end
        u2u_pkg::PEND_TWO: begin
          partial_nxt = partial_r | (cont6 << 6);
          pend_nxt    = u2u_pkg::PEND_ONE;
        end
        default: begin
          unit        = partial_r | cont6;
          partial_nxt = '0;
          pend_nxt    = u2u_pkg::PEND_LEAD;
          emit        = 1'b1;
        end
      endcase
    end
    units_nxt = emit ? units_inc : units_r;
    if (last_byte) begin
      // string ends: back to lead-byte state, counters cleared
      units_nxt   = '0;
      pend_nxt    = u2u_pkg::PEND_LEAD;
      partial_nxt = '0;
      stop_nxt    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r    <= u2u_pkg::PEND_LEAD;
      partial_r <= '0;
      units_r   <= '0;
      stop_r    <= 1'b0;
    end else if (accept) begin
      pend_r    <= pend_nxt;
      partial_r <= partial_nxt;
      units_r   <= units_nxt;
      stop_r    <= stop_nxt;
    end
  end

  assign result.emit       = emit;
  assign result.code_unit  = unit;
  assign result.unit_count = units_inc;

endmodule

`default_nettype wire

/* rtl/u2u_obuf.sv */
// Two-entry output buffer (result register plus skid) for decoded units.
// Depends on u2u_pkg.
`default_nettype none

module u2u_obuf (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       push,
  input  wire u2u_pkg::result_t           push_data,
  output logic                            space,
  output logic                            out_tvalid,
  input  wire logic                       out_tready,
  output logic [2*u2u_pkg::UNIT_W-1:0]    out_tdata
);

  logic                             main_v_r, main_v_nxt;
  logic                             skid_v_r, skid_v_nxt;
  logic [2*u2u_pkg::UNIT_W-1:0]     main_r,   main_nxt;
  logic [2*u2u_pkg::UNIT_W-1:0]     skid_r,   skid_nxt;
  logic [2*u2u_pkg::UNIT_W-1:0]     new_data;
  logic                             pop;
  logic                             wr;

  assign new_data = {push_data.unit_count, push_data.code_unit};
  assign wr       = push && push_data.emit;
  assign pop      = main_v_r && out_tready;

  always_comb begin
    main_v_nxt = main_v_r;
    skid_v_nxt = skid_v_r;
    main_nxt   = main_r;
    skid_nxt   = skid_r;
    if (pop && skid_v_r) begin
      main_nxt   = skid_r;
      skid_v_nxt = 1'b0;
    end else if (pop || !main_v_r) begin
      main_v_nxt = wr;
      main_nxt   = new_data;
    end else if (wr) begin
      skid_v_nxt = 1'b1;
      skid_nxt   = new_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      main_v_r <= main_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  assign space      = !skid_v_r;
  assign out_tvalid = main_v_r;
  assign out_tdata  = main_r;

endmodule

`default_nettype wire

/* rtl/utf8_to_ucs2_decoder_unit.sv */
// UTF-8 to UCS-2 decoder, top level: one byte per request in, one code unit per request out.
// A completing byte's unit is registered in the result register (or the skid slot) before it shows on out_*.
// Throughput: one byte per cycle; in_tready drops only when both output slots
// (result register and skid) hold units, i.e. after sustained out_tready low.
// Reset (rst_n low, synchronous): decode state cleared, buffer empty, unit_limit = 0xFFFF.
// Depends on u2u_pkg, u2u_core, u2u_obuf.
`default_nettype none

module utf8_to_ucs2_decoder_unit (
  input  wire logic         clk,
  input  wire logic         rst_n,
  // input request stream
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [7:0]   in_tdata,   // [7:0] in_byte
  input  wire logic         in_tlast,   // last_byte
  // result request stream
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [31:0]       out_tdata,  // [15:0] code_unit, [31:16] unit_count
  // configuration: unit_limit
  input  wire logic         cfg_wen,
  input  wire logic [15:0]  cfg_wdata
);

  logic [u2u_pkg::UNIT_W-1:0] unit_limit_r;
  logic                       accept;
  logic                       space;
  u2u_pkg::result_t           result;

  // Max units per string; the user must write it only while the decoder is idle (not enforced here).
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      unit_limit_r <= u2u_pkg::UNIT_LIMIT_RST;
    end else if (cfg_wen) begin
      unit_limit_r <= cfg_wdata;
    end
  end

  // Ready depends only on skid occupancy, so a byte is taken even while
  // the result register waits on the sink.
  assign in_tready = space;
  assign accept    = in_tvalid && space;

  // Decode state machine: updates on every accepted byte.
  u2u_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .in_byte    (in_tdata),
    .last_byte  (in_tlast),
    .unit_limit (unit_limit_r),
    .result     (result)
  );

  // Result register with skid slot.
  u2u_obuf u_obuf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (accept),
    .push_data  (result),
    .space      (space),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

`default_nettype wire

/* dv/utf8_to_ucs2_decoder_unit_test.sv */
// Self-checking testbench for utf8_to_ucs2_decoder_unit: directed and random UTF-8 strings
// go in, decoded code units are checked against a byte-level decode tracker.
// Depends on u2u_pkg and the decoder RTL.

// One decoded code unit as the result stream carries it
typedef struct packed {
  logic [15:0] unit_count;
  logic [15:0] code_unit;
} ucs2_unit_t;

// Tracks the decoder state per accepted byte and holds the code units still owed.
class unit_scoreboard;
  logic [15:0]  limit;
  logic [1:0]   pending;
  logic [15:0]  partial;
  logic [15:0]  emitted;
  logic         stopped;
  ucs2_unit_t   units_due[$];
  int unsigned  errors;

  function new();
    limit   = u2u_pkg::UNIT_LIMIT_RST;
    errors  = 0;
    clear_string();
  endfunction

  function void clear_string();
    pending = u2u_pkg::PEND_LEAD;
    partial = '0;
    emitted = '0;
    stopped = 1'b0;
  endfunction

  function void set_limit(logic [15:0] v);
    limit = v;
  endfunction

  function int outstanding();
    return units_due.size();
  endfunction

  // Advance the decode state by one accepted byte.
  function void note_byte(logic [7:0] b, logic last);
    logic        emit;
    logic [15:0] unit;
    ucs2_unit_t  u;
    emit = 1'b0;
    unit = '0;
    if (!stopped) begin
      if (pending == u2u_pkg::PEND_LEAD) begin
        if (emitted >= limit || b == 8'h00) begin
          stopped = 1'b1;
        end else if ((b & u2u_pkg::ASCII_MASK) == 8'h00) begin
          unit = {8'h00, b};
          emit = 1'b1;
        end else if ((b & u2u_pkg::LEAD2_MASK) == u2u_pkg::LEAD2_PAT) begin
          partial = {5'b0, b[4:0], 6'b0};
          pending = u2u_pkg::PEND_ONE;
        end else if ((b & u2u_pkg::LEAD3_MASK) == u2u_pkg::LEAD3_PAT) begin
          partial = {b[3:0], 12'b0};
          pending = u2u_pkg::PEND_TWO;
        end
      end else if (pending == u2u_pkg::PEND_TWO) begin
        partial = partial | {4'b0, b[5:0], 6'b0};
        pending = u2u_pkg::PEND_ONE;
      end else begin
        unit    = partial | {10'b0, b[5:0]};
        partial = '0;
        pending = u2u_pkg::PEND_LEAD;
        emit    = 1'b1;
      end
    end
    if (emit) begin
      emitted = emitted + 16'd1;
      u.code_unit  = unit;
      u.unit_count = emitted;
      units_due.insert(units_due.size(), u);
    end
    if (last) clear_string();
  endfunction

  function void check_unit(logic [31:0] d);
    ucs2_unit_t exp_u;
    if (units_due.size() == 0) begin
      $error("code unit 0x%04h with no unit owed", d[15:0]);
      errors++;
      return;
    end
    exp_u = units_due.pop_front();
    if (d[15:0] !== exp_u.code_unit) begin
      $error("code_unit expected 0x%04h actual 0x%04h", exp_u.code_unit, d[15:0]);
      errors++;
    end
    if (d[31:16] !== exp_u.unit_count) begin
      $error("unit_count expected %0d actual %0d", exp_u.unit_count, d[31:16]);
      errors++;
    end
  endfunction
endclass

module utf8_to_ucs2_decoder_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PHASE_BYTES = 100;  // random bytes per limit setting
  localparam int unsigned DRAIN_WAIT  = 4;    // cycles after the last unit before a cfg write

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // [7:0] in_byte
  logic        in_tlast;   // last_byte
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;  // [15:0] code_unit, [31:16] unit_count
  logic        cfg_wen;
  logic [15:0] cfg_wdata;

  // calm: no idling on either side for the tail of the run
  logic        calm = 1'b0;
  int unsigned bytes_sent;

  unit_scoreboard sb = new();

  utf8_to_ucs2_decoder_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Monitor: all TB drives are NBAs at the edge, so values read here are the
  // ones the DUT sampled. Input is noted before the result check on purpose:
  // a unit never leaves in the same edge its completing byte is accepted.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_byte(in_tdata, in_tlast);
      if (out_tvalid && out_tready) sb.check_unit(out_tdata);
    end
  end

  // Result side: ready in random runs, stalled in random bursts while not calm.
  initial begin
    out_tready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
  end

  // Hold one byte request until it is taken, then maybe leave a gap.
  // Entered and left on a clock edge; in_tvalid is only lowered for a gap.
  task automatic send_byte(input logic [7:0] b, input logic last);
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    bytes_sent++;
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  endtask

  // Stop the input, let every owed unit come out, then write unit_limit.
  // The first wait edge lets the monitor note the last accepted byte.
  task automatic write_limit(input logic [15:0] v);
    in_tvalid <= 1'b0;
    do @(posedge clk); while (sb.outstanding() != 0);
    repeat (DRAIN_WAIT) @(posedge clk);
    cfg_wen   <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_wen   <= 1'b0;
    sb.set_limit(v);
  endtask

  function automatic logic [7:0] cont_byte();
    // mostly proper 10xxxxxx, sometimes anything (continuations are unchecked)
    if ($urandom_range(0, 9) == 0) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(8'h80, 8'hBF));
  endfunction

  // One random string: mostly well-formed sequences, some noise, an occasional
  // NUL terminator and an occasional sequence cut off by the last byte.
  task automatic random_string();
    logic [7:0]  q[$];
    int unsigned n_tok;
    int unsigned nul_at;
    n_tok  = $urandom_range(1, 10);
    nul_at = ($urandom_range(0, 9) == 0) ? $urandom_range(0, n_tok - 1) : n_tok + 1;
    for (int unsigned t = 0; t < n_tok; t++) begin
      if (t == nul_at) q.insert(q.size(), 8'h00);
      case ($urandom_range(0, 9))
        0, 1, 2, 3: q.insert(q.size(), 8'($urandom_range(8'h01, 8'h7F)));
        4, 5: begin
          q.insert(q.size(), 8'($urandom_range(8'hC0, 8'hDF)));
          q.insert(q.size(), cont_byte());
        end
        6, 7: begin
          q.insert(q.size(), 8'($urandom_range(8'hE0, 8'hEF)));
          q.insert(q.size(), cont_byte());
          q.insert(q.size(), cont_byte());
        end
        8: q.insert(q.size(), 8'($urandom_range(0, 255)));
        default: begin
          // stray continuation or 4-byte-and-up lead
          if ($urandom_range(0, 1) == 0) q.insert(q.size(), 8'($urandom_range(8'h80, 8'hBF)));
          else q.insert(q.size(), 8'($urandom_range(8'hF0, 8'hFF)));
        end
      endcase
    end
    if ($urandom_range(0, 7) == 0) begin
      // cut-off tail
      if ($urandom_range(0, 1) == 0) begin
        q.insert(q.size(), 8'($urandom_range(8'hC0, 8'hDF)));
      end else begin
        q.insert(q.size(), 8'($urandom_range(8'hE0, 8'hEF)));
        if ($urandom_range(0, 1) == 0) q.insert(q.size(), cont_byte());
      end
    end
    foreach (q[i]) send_byte(q[i], i == q.size() - 1);
  endtask

  initial begin
    logic [15:0] phase_limit[7];
    int unsigned phase_end;

    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    in_tlast   <= 1'b0;
    cfg_wen    <= 1'b0;
    cfg_wdata  <= '0;
    bytes_sent = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---- directed part, reset limit (0xFFFF) ----
    send_byte(8'h01, 1'b0);                          // smallest nonzero ASCII
    send_byte(8'h7F, 1'b0);                          // largest ASCII
    send_byte(8'hC2, 1'b0); send_byte(8'h80, 1'b0);  // 2-byte low end
    send_byte(8'hDF, 1'b0); send_byte(8'hBF, 1'b0);  // 2-byte top
    send_byte(8'hE0, 1'b0); send_byte(8'h80, 1'b0); send_byte(8'h80, 1'b0);
    send_byte(8'hEF, 1'b0); send_byte(8'hBF, 1'b0); send_byte(8'hBF, 1'b0);
    send_byte(8'hF0, 1'b0);                          // 4-byte lead dropped
    send_byte(8'h80, 1'b0);                          // stray continuation dropped
    send_byte(8'hFF, 1'b0);
    send_byte(8'hC2, 1'b0); send_byte(8'h00, 1'b0);  // NUL as following byte
    send_byte(8'hE2, 1'b0); send_byte(8'h82, 1'b1);  // cut off by last byte
    send_byte(8'h00, 1'b0);                          // NUL lead stops the string
    send_byte(8'h41, 1'b0); send_byte(8'h42, 1'b1);  // ignored until last
    // limit of zero: nothing comes out
    write_limit(16'h0000);
    send_byte(8'h41, 1'b1);
    // limit change mid-string: applies from the next lead byte
    write_limit(16'h0001);
    send_byte(8'h41, 1'b0);
    write_limit(16'h0003);
    send_byte(8'h42, 1'b0); send_byte(8'h43, 1'b0); send_byte(8'h44, 1'b1);

    // ---- random part: one limit setting per phase ----
    phase_limit[0] = 16'hFFFF;
    phase_limit[1] = 16'h0000;
    phase_limit[2] = 16'h0001;
    phase_limit[3] = 16'($urandom_range(2, 10));
    phase_limit[4] = 16'($urandom_range(0, 16'hFFFF));
    phase_limit[5] = 16'h0003;
    phase_limit[6] = 16'hFFFF;
    foreach (phase_limit[p]) begin
      if (p == 6) calm = 1'b1;  // tail of the run: no idling anywhere
      write_limit(phase_limit[p]);
      phase_end = bytes_sent + PHASE_BYTES;
      while (bytes_sent < phase_end) begin
        random_string();
        // occasional hold-off until every owed unit is out
        if (!calm && $urandom_range(0, 15) == 0) begin
          in_tvalid <= 1'b0;
          do @(posedge clk); while (sb.outstanding() != 0);
        end
      end
    end

    // ---- drain and verdict ----
    in_tvalid <= 1'b0;
    do @(posedge clk); while (sb.outstanding() != 0);
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

/* files.f */
rtl/u2u_pkg.sv
rtl/u2u_core.sv
rtl/u2u_obuf.sv
rtl/utf8_to_ucs2_decoder_unit.sv
dv/utf8_to_ucs2_decoder_unit_test.sv
